[rtl/ptwg_pkg.sv]
package ptwg_pkg;

  // Number of sine steps before the index wraps; the table itself has eight entries.
  localparam int SINE_ENTRIES = 8;
  localparam int SINE_IW = (SINE_ENTRIES > 1) ? $clog2(SINE_ENTRIES) : 1;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_RX     = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [7:0] CHAR_SINE   = 8'h73;
  localparam logic [7:0] CHAR_TRI    = 8'h74;
  localparam logic [7:0] CHAR_RAMP   = 8'h72;
  localparam logic [7:0] CHAR_SQUARE = 8'h71;

  // Distance is (897000 - 243*sample) / 16000. The divide by 16000 is a shift
  // by 7 followed by a divide by 125, done as a multiply by ceil(2^20/125).
  localparam int SAMPLE_GAIN = 243;
  localparam int DIST_OFFSET = 897000;
  localparam int PRE_SHIFT   = 7;
  localparam int RECIP       = 8389;
  localparam int RECIP_SHIFT = 20;

  localparam int PER_SQ_GAIN  = 500;
  localparam int PER_SQ_BASE  = 5000;
  localparam int PER_WV_GAIN  = 330;
  localparam int PER_WV_BASE  = 3200;

  localparam logic [7:0] LEVEL_TOP = 8'd15;
  localparam logic [7:0] TRI_UP    = 8'd3;
  localparam logic [7:0] TRI_DOWN  = 8'hFD;
  localparam logic [7:0] RAMP_UP   = 8'd2;
  localparam logic [7:0] RAMP_WRAP = 8'd15;

  typedef struct packed {
    logic              valid;
    logic [1:0]        opcode;
    logic [7:0]        rx_byte;
    logic signed [6:0] distance;
  } item_t;

  function automatic logic [7:0] sine_lookup(input logic [SINE_IW-1:0] idx);
    logic [SINE_IW+2:0] wide;
    logic [2:0]         tidx;
    wide = {3'b000, idx};
    tidx = wide[2:0];
    case (tidx)
      3'd0: sine_lookup = 8'd8;
      3'd1: sine_lookup = 8'd13;
      3'd2: sine_lookup = 8'd15;
      3'd3: sine_lookup = 8'd13;
      3'd4: sine_lookup = 8'd8;
      3'd5: sine_lookup = 8'd2;
      3'd6: sine_lookup = 8'd0;
      3'd7: sine_lookup = 8'd2;
      default: sine_lookup = 8'd0;
    endcase
  endfunction

endpackage

[rtl/ptwg_dist.sv]
module ptwg_dist (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic          item_valid,
  input  logic [1:0]    opcode,
  input  logic [11:0]   sample,
  input  logic [7:0]    rx_byte,
  output ptwg_pkg::item_t item
);
  import ptwg_pkg::*;

  // First stage: scaled sample.
  logic        v1;
  logic [1:0]  op1;
  logic [7:0]  byte1;
  logic [19:0] prod1;

  // Second stage: signed distance.
  logic signed [20:0] num;
  logic               neg;
  logic [19:0]        mag;
  logic [12:0]        x;
  logic [26:0]        qprod;
  logic [5:0]         q;
  logic signed [6:0]  dist_cm;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      item.valid <= 1'b0;
    end else if (advance) begin
      v1 <= item_valid;
      item.valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      op1   <= opcode;
      byte1 <= rx_byte;
      prod1 <= 20'(sample) * 20'(SAMPLE_GAIN);
      item.opcode   <= op1;
      item.rx_byte  <= byte1;
      item.distance <= dist_cm;
    end
  end

  always_comb begin
    num     = 21'(DIST_OFFSET) - $signed({1'b0, prod1});
    neg     = num[20];
    mag     = neg ? 20'(-num) : num[19:0];
    x       = mag[19:PRE_SHIFT];
    qprod   = 27'(x) * 27'(RECIP);
    q       = qprod[RECIP_SHIFT +: 6];
    dist_cm = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  end

endmodule

[rtl/ptwg_core.sv]
module ptwg_core (
  input  logic            clk,
  input  logic            rst,
  input  ptwg_pkg::item_t item,
  input  logic            result_stall,
  output logic            advance,
  output logic            result_valid,
  output logic [7:0]      level,
  output logic [14:0]     period,
  output logic signed [6:0] distance,
  output logic            echo_valid,
  output logic [7:0]      echo_byte,
  output logic [7:0]      wave_select
);
  import ptwg_pkg::*;

  logic [7:0]          step_amount;
  logic [SINE_IW-1:0]  sine_idx;
  logic [14:0]         tick_count;

  logic [7:0]          level_next;
  logic [7:0]          step_next;
  logic [SINE_IW-1:0]  sine_next;
  logic [7:0]          wave_next;
  logic [14:0]         period_next;
  logic [14:0]         tick_next;
  logic signed [6:0]   distance_next;
  logic                echo_valid_next;
  logic [7:0]          echo_byte_next;
  logic [5:0]          dmag;

  assign advance = !result_valid || !result_stall;

  always_comb begin
    level_next      = level;
    step_next       = step_amount;
    sine_next       = sine_idx;
    wave_next       = wave_select;
    period_next     = period;
    tick_next       = tick_count;
    distance_next   = distance;
    echo_valid_next = 1'b0;
    echo_byte_next  = 8'd0;
    dmag            = item.distance[5:0];
    case (item.opcode)
      OP_SAMPLE: begin
        distance_next = item.distance;
        if (item.distance >= 7'sd10 && item.distance <= 7'sd40) begin
          if (wave_select == CHAR_SQUARE) begin
            period_next = 15'(dmag) * 15'(PER_SQ_GAIN) + 15'(PER_SQ_BASE);
          end else begin
            period_next = 15'(dmag) * 15'(PER_WV_GAIN) - 15'(PER_WV_BASE);
          end
        end else if (item.distance > 7'sd50) begin
          period_next = 15'd0;
          level_next  = 8'd0;
        end
      end
      OP_RX: begin
        echo_valid_next = 1'b1;
        echo_byte_next  = item.rx_byte;
        wave_next       = item.rx_byte;
      end
      OP_TICK: begin
        if (period != 15'd0) begin
          tick_next = (tick_count >= period) ? 15'd0 : tick_count + 15'd1;
          if (tick_next == period) begin
            if (wave_select == CHAR_SINE) begin
              level_next = sine_lookup(sine_idx);
              sine_next  = (sine_idx == SINE_IW'(SINE_ENTRIES - 1)) ? '0 : sine_idx + 1'b1;
            end else if (wave_select == CHAR_TRI) begin
              if (level == 8'd0) begin
                step_next = TRI_UP;
              end else if (level == LEVEL_TOP) begin
                step_next = TRI_DOWN;
              end
              level_next = level + step_next;
            end else if (wave_select == CHAR_RAMP) begin
              if (level == 8'd0) begin
                step_next  = RAMP_UP;
                level_next = 8'd1;
              end else if (level == LEVEL_TOP) begin
                step_next  = RAMP_WRAP;
                level_next = 8'd0;
              end else begin
                level_next = level + step_amount;
              end
            end else begin
              level_next = (level == 8'd0) ? LEVEL_TOP : 8'd0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      level        <= 8'd0;
      step_amount  <= 8'd0;
      sine_idx     <= '0;
      wave_select  <= CHAR_SQUARE;
      period       <= 15'd0;
      tick_count   <= 15'd0;
      distance     <= 7'sd0;
      echo_valid   <= 1'b0;
      echo_byte    <= 8'd0;
    end else if (advance) begin
      result_valid <= item.valid;
      echo_valid   <= 1'b0;
      echo_byte    <= 8'd0;
      if (item.valid) begin
        level       <= level_next;
        step_amount <= step_next;
        sine_idx    <= sine_next;
        wave_select <= wave_next;
        period      <= period_next;
        tick_count  <= tick_next;
        distance    <= distance_next;
        echo_valid  <= echo_valid_next;
        echo_byte   <= echo_byte_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_echo_has_beat: assert property (@(posedge clk) disable iff (rst)
    echo_valid |-> result_valid) else $error("echo flag without a result beat");

  a_echo_sets_wave: assert property (@(posedge clk) disable iff (rst)
    echo_valid |-> wave_select == echo_byte) else $error("echoed byte not selected");

  a_sine_range: assert property (@(posedge clk) disable iff (rst)
    sine_idx <= SINE_IW'(SINE_ENTRIES - 1)) else $error("sine index out of range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(level) && $stable(period) && $stable(wave_select))
    else $error("state changed while result stalled");
`endif

endmodule

[rtl/proximity_tone_waveform_generator.sv]
// Proximity tone waveform generator.
// The input channel (item_valid / item_stall) carries one event per beat:
// opcode 0 is a 12-bit distance-sensor sample, opcode 1 is a received serial
// byte that selects the waveform, opcode 2 is one tick of the tone timer.
// The result channel (result_valid / result_stall) returns exactly one beat
// per input beat, in order: level, period, distance, the echo of a received
// byte, and the selected waveform character, all as they stand after the
// event.
// The sample is scaled on its way into the first register, the distance in
// cm is formed with a reciprocal multiply on its way into the second, and
// the tone state is updated into the result register. One beat is accepted
// every cycle while the receiver does not stall; the state update is the
// only stage with feedback and it is computed ahead of the result register.
// When the receiver stalls while a result is held, the whole pipeline
// freezes and item_stall is raised in the same cycle; nothing is dropped.
// Synchronous reset empties the pipeline, stops the timer (period 0), zeroes
// the level and distance, and selects the square wave.
module proximity_tone_waveform_generator (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [1:0]        opcode,
  input  logic [11:0]       sample,
  input  logic [7:0]        rx_byte,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [7:0]        level,
  output logic [14:0]       period,
  output logic signed [6:0] distance,
  output logic              echo_valid,
  output logic [7:0]        echo_byte,
  output logic [7:0]        wave_select
);
  import ptwg_pkg::*;

  // Pipeline advance: every stage moves when the result register is free.
  logic  advance;
  item_t item;

  assign item_stall = !advance;

  // Sample scaling and distance division.
  ptwg_dist u_dist (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .item_valid (item_valid),
    .opcode     (opcode),
    .sample     (sample),
    .rx_byte    (rx_byte),
    .item       (item)
  );

  // Tone state, waveform stepping and the result register.
  ptwg_core u_core (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .result_stall (result_stall),
    .advance      (advance),
    .result_valid (result_valid),
    .level        (level),
    .period       (period),
    .distance     (distance),
    .echo_valid   (echo_valid),
    .echo_byte    (echo_byte),
    .wave_select  (wave_select)
  );

endmodule

[bench/ptwg_tone_checker.sv]
`timescale 1ns / 100ps

// Watches both channels of the tone generator. It predicts one result beat
// for every accepted input beat and compares the result beats in order.
module ptwg_tone_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  logic [1:0]        opcode,
  input  logic [11:0]       sample,
  input  logic [7:0]        rx_byte,
  input  logic              result_valid,
  input  logic              result_stall,
  input  logic [7:0]        level,
  input  logic [14:0]       period,
  input  logic signed [6:0] distance,
  input  logic              echo_valid,
  input  logic [7:0]        echo_byte,
  input  logic [7:0]        wave_select,
  output int                errors,
  output int                pending,
  output int                checked,
  output int                steps
);
  import ptwg_pkg::*;

  typedef struct packed {
    logic [7:0]        level;
    logic [14:0]       period;
    logic signed [6:0] distance;
    logic              echo_valid;
    logic [7:0]        echo_byte;
    logic [7:0]        wave_select;
  } tone_result_t;

  // Sine levels with entry 0 in the low byte.
  localparam logic [63:0] SINE_LEVELS =
    {8'd2, 8'd0, 8'd2, 8'd8, 8'd13, 8'd15, 8'd13, 8'd8};

  tone_result_t tone_results_q[$];

  logic [7:0]  lvl_q;
  logic [7:0]  slope_q;
  logic [7:0]  wave_q;
  int unsigned phase_q;
  int unsigned per_q;
  int unsigned cnt_q;
  int          dist_q;
  int          n_err;
  int          n_checked;
  int          n_steps;

  always @(posedge clk) begin : watch
    tone_result_t want;
    tone_result_t got;
    int           cm;
    if (rst) begin
      lvl_q     = '0;
      slope_q   = '0;
      wave_q    = CHAR_SQUARE;
      phase_q   = 0;
      per_q     = 0;
      cnt_q     = 0;
      dist_q    = 0;
      n_err     = 0;
      n_checked = 0;
      n_steps   = 0;
      tone_results_q.delete();
    end else begin
      if (result_valid && !result_stall) begin
        got = {level, period, distance, echo_valid, echo_byte, wave_select};
        if (tone_results_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) begin
            $display("unexpected result beat: level %0d period %0d distance %0d wave %0d",
                     level, period, distance, wave_select);
          end
        end else begin
          want = tone_results_q.pop_front();
          n_checked++;
          if (got !== want) begin
            n_err++;
            if (n_err <= 10) begin
              $display("result %0d mismatch (expected/actual): level %0d/%0d period %0d/%0d",
                       n_checked, want.level, got.level, want.period, got.period);
              $display("  distance %0d/%0d echo %0b,%0d/%0b,%0d wave %0d/%0d",
                       want.distance, got.distance, want.echo_valid, want.echo_byte,
                       got.echo_valid, got.echo_byte, want.wave_select, got.wave_select);
            end
          end
        end
      end

      if (item_valid && !item_stall) begin
        want.echo_valid = 1'b0;
        want.echo_byte  = '0;
        case (opcode)
          OP_SAMPLE: begin
            cm     = (DIST_OFFSET - SAMPLE_GAIN * int'(sample)) / 16000;
            dist_q = cm;
            if (cm >= 10 && cm <= 40) begin
              if (wave_q == CHAR_SQUARE) per_q = cm * PER_SQ_GAIN + PER_SQ_BASE;
              else per_q = cm * PER_WV_GAIN - PER_WV_BASE;
            end else if (cm > 50) begin
              per_q = 0;
              lvl_q = '0;
            end
          end
          OP_RX: begin
            wave_q          = rx_byte;
            want.echo_valid = 1'b1;
            want.echo_byte  = rx_byte;
          end
          OP_TICK: begin
            if (per_q != 0) begin
              if (cnt_q >= per_q) cnt_q = 0;
              else cnt_q++;
              if (cnt_q == per_q) begin
                n_steps++;
                case (wave_q)
                  CHAR_SINE: begin
                    lvl_q = SINE_LEVELS[8 * (phase_q % 8) +: 8];
                    if (phase_q >= SINE_ENTRIES - 1) phase_q = 0;
                    else phase_q++;
                  end
                  CHAR_TRI: begin
                    if (lvl_q == 0) slope_q = TRI_UP;
                    else if (lvl_q == LEVEL_TOP) slope_q = TRI_DOWN;
                    lvl_q = lvl_q + slope_q;
                  end
                  CHAR_RAMP: begin
                    if (lvl_q == 0) begin
                      slope_q = RAMP_UP;
                      lvl_q   = 8'd1;
                    end else if (lvl_q == LEVEL_TOP) begin
                      slope_q = RAMP_WRAP;
                      lvl_q   = 8'd0;
                    end else begin
                      lvl_q = lvl_q + slope_q;
                    end
                  end
                  default: begin
                    lvl_q = (lvl_q == 0) ? LEVEL_TOP : 8'd0;
                  end
                endcase
              end
            end
          end
          default: begin
          end
        endcase
        want.level       = lvl_q;
        want.period      = per_q[14:0];
        want.distance    = dist_q[6:0];
        want.wave_select = wave_q;
        tone_results_q.push_back(want);
      end
    end
    errors  <= n_err;
    pending <= tone_results_q.size();
    checked <= n_checked;
    steps   <= n_steps;
  end

endmodule

[bench/proximity_tone_waveform_generator_tb.sv]
`timescale 1ns / 100ps

// Top of the bench for the proximity tone waveform generator. This module
// only makes stimulus and gives the verdict; the checker beside the block
// predicts every result beat and counts the mismatches.
module proximity_tone_waveform_generator_tb;
  import ptwg_pkg::*;

  // The fourth opcode is not decoded by the block; it must leave the state
  // alone and still return a result beat.
  localparam logic [1:0] OP_QUIET = 2'd3;

  localparam int NOISE_ITEMS  = 150;
  localparam int TONE_RUNS    = 5;
  localparam int CALM_RUNS    = 2;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 5_000_000;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  logic              result_stall = 1'b0;
  logic [1:0]        opcode       = OP_QUIET;
  logic [11:0]       sample       = '0;
  logic [7:0]        rx_byte      = '0;
  logic              item_stall;
  logic              result_valid;
  logic [7:0]        level;
  logic [14:0]       period;
  logic signed [6:0] distance;
  logic              echo_valid;
  logic [7:0]        echo_byte;
  logic [7:0]        wave_select;

  int errors;
  int pending;
  int checked;
  int steps;

  // Set by the stimulus: calm turns idling off on both sides for the last
  // part of the run, hold_req asks the receiver for one long hold-off.
  bit calm     = 1'b0;
  bit hold_req = 1'b0;

  int sent     = 0;
  int n_sample = 0;
  int n_rx     = 0;
  int n_tick   = 0;
  int n_quiet  = 0;
  int cycles   = 0;

  always #5 clk = ~clk;

  proximity_tone_waveform_generator u_dut (.*);

  ptwg_tone_checker u_checker (.*);

  // A generous watchdog; a healthy run finishes far below this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Sample value that lands exactly on the given distance in cm. The floor
  // keeps the numerator within 243 of a multiple of 16000, so the truncated
  // quotient is the distance itself for any distance from 0 to 56.
  function automatic logic [11:0] sample_at_cm(input int cm);
    sample_at_cm = 12'((DIST_OFFSET - 16000 * cm) / SAMPLE_GAIN);
  endfunction

  // Waveform characters by number; anything past the four named waves is a
  // random byte, which the block plays as a square wave.
  function automatic logic [7:0] pick_wave(input int k);
    case (k)
      0:       pick_wave = CHAR_SINE;
      1:       pick_wave = CHAR_TRI;
      2:       pick_wave = CHAR_RAMP;
      3:       pick_wave = CHAR_SQUARE;
      default: pick_wave = 8'($urandom);
    endcase
  endfunction

  // Offers one beat and returns at the edge that accepts it. Every call
  // starts right after a rising edge, so valid is assigned at most once per
  // time step: it stays high from one beat to the next unless an idle burst
  // lowers it first. During the calm part no bursts are inserted.
  task automatic offer_event(input logic [1:0] op, input logic [11:0] smp,
                             input logic [7:0] ch);
    if (!calm && $urandom_range(0, 9) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    item_valid <= 1'b1;
    opcode     <= op;
    sample     <= smp;
    rx_byte    <= ch;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sent++;
    case (op)
      OP_SAMPLE: n_sample++;
      OP_RX:     n_rx++;
      OP_TICK:   n_tick++;
      default:   n_quiet++;
    endcase
  endtask

  // Receiver. It stalls in random bursts, once holds off for a long stretch
  // so the pipeline fills and the block pushes back on its input, and stops
  // stalling altogether once the run turns calm. Each pass assigns the
  // stall once and then lets at least one edge go by.
  initial begin : receiver
    bit held;
    held = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        result_stall <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int          roll;
    int          start;
    int          cm;
    int          reps;
    int          span;
    int          ticks;
    logic [7:0]  wave;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats. Right after reset the timer is stopped and the square
    // wave is selected, so the first tick must change nothing.
    offer_event(OP_QUIET, 12'hFFF, 8'hFF);
    offer_event(OP_TICK, 12'h000, 8'h00);
    // Both ends of the sample range: the lowest sample gives the largest distance
    // and stops the tone, the highest gives the most negative distance.
    offer_event(OP_SAMPLE, 12'h000, 8'h00);
    offer_event(OP_SAMPLE, 12'hFFF, 8'h00);
    // A small negative numerator must truncate toward zero, a larger one
    // must give minus one.
    offer_event(OP_SAMPLE, 12'd3700, 8'h00);
    offer_event(OP_SAMPLE, 12'd3760, 8'h00);
    // Square-wave periods at the edges of the active band, then distances
    // just outside it, which leave the period where it was.
    offer_event(OP_SAMPLE, sample_at_cm(10), 8'h00);
    offer_event(OP_SAMPLE, sample_at_cm(40), 8'h00);
    offer_event(OP_SAMPLE, sample_at_cm(41), 8'h00);
    offer_event(OP_SAMPLE, sample_at_cm(50), 8'h00);
    offer_event(OP_SAMPLE, sample_at_cm(9), 8'h00);
    offer_event(OP_TICK, 12'hFFF, 8'hFF);
    offer_event(OP_TICK, 12'h000, 8'h00);
    // Just past fifty the timer stops and the level drops.
    offer_event(OP_SAMPLE, sample_at_cm(51), 8'h00);
    // The other period formula applies once a non-square wave is selected.
    offer_event(OP_RX, 12'h000, CHAR_SINE);
    offer_event(OP_SAMPLE, sample_at_cm(10), 8'h00);
    offer_event(OP_SAMPLE, sample_at_cm(40), 8'h00);
    offer_event(OP_RX, 12'h000, CHAR_TRI);
    offer_event(OP_RX, 12'h000, CHAR_RAMP);
    offer_event(OP_RX, 12'h000, 8'h00);
    offer_event(OP_RX, 12'h000, 8'hFF);
    offer_event(OP_RX, 12'h000, 8'hA5);
    offer_event(OP_SAMPLE, 12'hAAA, 8'h55);
    offer_event(OP_SAMPLE, 12'h555, 8'hAA);
    offer_event(OP_QUIET, 12'h000, 8'h00);

    // Mixed traffic with random content: samples anywhere in range, wave
    // changes, short runs of ticks and the odd undecoded opcode. The long
    // receiver hold-off happens early in this part.
    hold_req = 1'b1;
    start = sent;
    while (sent - start < NOISE_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        if ($urandom_range(0, 4) < 3) begin
          offer_event(OP_SAMPLE, sample_at_cm($urandom_range(8, 53)), 8'($urandom));
        end else begin
          offer_event(OP_SAMPLE, 12'($urandom), 8'($urandom));
        end
      end else if (roll < 45) begin
        if ($urandom_range(0, 9) < 7) begin
          offer_event(OP_RX, 12'($urandom), pick_wave($urandom_range(0, 3)));
        end else begin
          offer_event(OP_RX, 12'($urandom), 8'($urandom));
        end
      end else if (roll < 95) begin
        repeat ($urandom_range(1, 30)) offer_event(OP_TICK, 12'($urandom), 8'($urandom));
      end else begin
        offer_event(OP_QUIET, 12'($urandom), 8'($urandom));
      end
    end

    // Tone runs. Each one sets a short period with the sine wave selected,
    // so the non-square formula applies, then switches to the wave under
    // test and ticks through one or more full periods. That is the only way to
    // walk a waveform through many steps, since the shortest period is 100.
    // A few harmless beats are mixed into the ticks: undecoded opcodes,
    // repeats of the same wave and distances that leave the period alone.
    // Each run plays a different wave; the last two are calm.
    for (int run = 0; run < TONE_RUNS; run++) begin
      if (run == TONE_RUNS - CALM_RUNS) calm = 1'b1;
      wave = pick_wave((run < 5) ? run : $urandom_range(0, 4));
      cm   = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 12) : 10;
      reps = (cm == 10) ? $urandom_range(2, 3) : 1;
      span = (cm * PER_WV_GAIN - PER_WV_BASE + 1) * reps;
      offer_event(OP_RX, 12'($urandom), CHAR_SINE);
      offer_event(OP_SAMPLE, sample_at_cm(cm), 8'($urandom));
      offer_event(OP_RX, 12'($urandom), wave);
      ticks = 0;
      while (ticks < span) begin
        if ($urandom_range(0, 63) == 0) begin
          case ($urandom_range(0, 3))
            0:       offer_event(OP_QUIET, 12'($urandom), 8'($urandom));
            1:       offer_event(OP_RX, 12'($urandom), wave);
            2:       offer_event(OP_SAMPLE, sample_at_cm($urandom_range(41, 50)),
                                 8'($urandom));
            default: offer_event(OP_SAMPLE, 12'($urandom_range(3700, 4095)),
                                 8'($urandom));
          endcase
        end else begin
          offer_event(OP_TICK, 12'($urandom), 8'($urandom));
          ticks++;
        end
      end
    end

    // Let every outstanding result beat drain, then allow for the
    // pipeline latency so a stray extra beat would still be caught.
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d samples, %0d serial bytes, %0d timer ticks and %0d undecoded beats,",
             n_sample, n_rx, n_tick, n_quiet);
    $display("with %0d waveform steps predicted and %0d result beats compared.",
             steps, checked);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
